// ===== sv/efcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Escaped frame CRC decoder package
// Shared types and constants: configuration, classified byte token, result.
// ----------------------------------------------------------------------------
package efcd_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 40;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MAX_PAYLOAD   = 3'd0,
		REG_BEGIN_CODE    = 3'd1,
		REG_END_CODE      = 3'd2,
		REG_CRC_CODE      = 3'd3,
		REG_FILL_CODE     = 3'd4,
		REG_ESCAPE_CODE   = 3'd5,
		REG_ESCAPED_CODES = 3'd6
	} cfg_reg_t;

	localparam logic [15:0] RST_MAX_PAYLOAD   = 16'd256;
	localparam logic [7:0]  RST_BEGIN_CODE    = 8'd2;
	localparam logic [7:0]  RST_END_CODE      = 8'd3;
	localparam logic [7:0]  RST_CRC_CODE      = 8'd4;
	localparam logic [7:0]  RST_FILL_CODE     = 8'd30;
	localparam logic [7:0]  RST_ESCAPE_CODE   = 8'd36;
	localparam logic [39:0] RST_ESCAPED_CODES = 40'd0;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef enum logic [2:0] {
		KIND_PAYLOAD  = 3'd0,
		KIND_GOOD     = 3'd1,
		KIND_BADCRC   = 3'd2,
		KIND_MARKER   = 3'd3,
		KIND_OVERFLOW = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CRC     = 2'd2
	} phase_t;

	typedef struct packed {
		logic [15:0] max_payload;
		logic [7:0]  begin_code;
		logic [7:0]  end_code;
		logic [7:0]  crc_code;
		logic [7:0]  fill_code;
		logic [7:0]  escape_code;
		logic [39:0] escaped_codes;
	} cfg_t;

	typedef struct packed {
		logic [7:0] raw;
		logic [7:0] unesc;
		logic       is_begin;
		logic       is_fill;
		logic       is_end;
		logic       is_crc;
		logic       is_esc;
	} token_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] frame_length;
		logic [15:0] received_crc;
		logic [15:0] computed_crc;
	} result_t;

	localparam int unsigned TOKEN_W  = $bits(token_t);
	localparam int unsigned RESULT_W = $bits(result_t);

endpackage

// ===== sv/efcd_fifo.sv =====
// ----------------------------------------------------------------------------
// Escaped frame CRC decoder queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module efcd_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/efcd_front.sv =====
// ----------------------------------------------------------------------------
// Escaped frame CRC decoder front end
// Classifies a received byte against the marker codes and decodes its
// escaped value, producing one token per byte.
// ----------------------------------------------------------------------------
module efcd_front import efcd_pkg::*; (
	input  cfg_t       cfg,
	input  logic [7:0] rx_byte,
	output token_t     tok
);

	logic [7:0] targets [5];
	logic [7:0] unesc;

	assign targets[0] = cfg.begin_code;
	assign targets[1] = cfg.end_code;
	assign targets[2] = cfg.crc_code;
	assign targets[3] = cfg.fill_code;
	assign targets[4] = cfg.escape_code;

	// lower table entry wins
	always_comb begin
		unesc = 8'd0;
		for (int k = 4; k >= 0; k--) begin
			if (cfg.escaped_codes[8*k +: 8] == rx_byte) begin
				unesc = targets[k];
			end
		end
	end

	always_comb begin
		tok.raw      = rx_byte;
		tok.unesc    = unesc;
		tok.is_begin = (rx_byte == cfg.begin_code);
		tok.is_fill  = (rx_byte == cfg.fill_code);
		tok.is_end   = (rx_byte == cfg.end_code);
		tok.is_crc   = (rx_byte == cfg.crc_code);
		tok.is_esc   = (rx_byte == cfg.escape_code);
	end

endmodule

// ===== sv/efcd_back.sv =====
// ----------------------------------------------------------------------------
// Escaped frame CRC decoder back end
// Frame state machine: tracks phase and escapes, counts payload, folds the
// CRC-16 a byte per unstalled cycle and produces payload and verdict results.
// ----------------------------------------------------------------------------
module efcd_back import efcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] max_payload,
	input  logic        tok_valid,
	input  token_t      tok,
	output logic        tok_pop,
	input  logic        res_full,
	output logic        res_push,
	output result_t     res
);

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_OPEN,
		ACT_ESC,
		ACT_TO_CRC,
		ACT_PAYLOAD,
		ACT_CRC_BYTE,
		ACT_VERDICT
	} act_t;

	function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	phase_t      phase_q, phase_d;
	logic        esc_q;
	logic [15:0] count_q;
	logic [1:0]  crc_cnt_q;
	logic [15:0] rcrc_q;
	logic [15:0] ccrc_q;

	logic        step;
	logic        in_frame;
	logic        is_data;
	logic [7:0]  dbyte;
	act_t        act;
	kind_t       vkind;

	assign step     = tok_valid && !res_full;
	assign tok_pop  = step;
	assign in_frame = (phase_q != PH_HUNT);

	always_comb begin
		is_data = 1'b0;
		dbyte   = tok.raw;
		act     = ACT_NONE;
		vkind   = KIND_MARKER;
		if (esc_q && in_frame) begin
			is_data = 1'b1;
			dbyte   = tok.unesc;
		end else if (tok.is_begin) begin
			act = in_frame ? ACT_VERDICT : ACT_OPEN;
		end else if (tok.is_fill) begin
			act = ACT_NONE;
		end else if (tok.is_end) begin
			act = ACT_VERDICT;
			if (phase_q == PH_CRC) begin
				vkind = (rcrc_q == ccrc_q) ? KIND_GOOD : KIND_BADCRC;
			end
		end else if (tok.is_crc) begin
			act = (phase_q == PH_PAYLOAD) ? ACT_TO_CRC : ACT_VERDICT;
		end else if (!in_frame) begin
			act = ACT_NONE;
		end else if (tok.is_esc) begin
			act = ACT_ESC;
		end else begin
			is_data = 1'b1;
		end
		if (is_data) begin
			if (phase_q == PH_PAYLOAD) begin
				if (count_q >= max_payload) begin
					act   = ACT_VERDICT;
					vkind = KIND_OVERFLOW;
				end else begin
					act = ACT_PAYLOAD;
				end
			end else if (crc_cnt_q >= 2'd2) begin
				act   = ACT_VERDICT;
				vkind = KIND_OVERFLOW;
			end else begin
				act = ACT_CRC_BYTE;
			end
		end
	end

	always_comb begin
		case (act)
			ACT_OPEN:    phase_d = PH_PAYLOAD;
			ACT_TO_CRC:  phase_d = PH_CRC;
			ACT_VERDICT: phase_d = PH_HUNT;
			default:     phase_d = phase_q;
		endcase
	end

	always_comb begin
		res_push         = 1'b0;
		res.kind         = vkind;
		res.data_byte    = 8'd0;
		res.frame_length = count_q;
		res.received_crc = rcrc_q;
		res.computed_crc = ccrc_q;
		case (act)
			ACT_PAYLOAD: begin
				res_push         = step;
				res.kind         = KIND_PAYLOAD;
				res.data_byte    = dbyte;
				res.frame_length = 16'd0;
				res.received_crc = 16'd0;
				res.computed_crc = 16'd0;
			end
			ACT_VERDICT: begin
				res_push = step;
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			esc_q     <= 1'b0;
			count_q   <= '0;
			crc_cnt_q <= '0;
			rcrc_q    <= '0;
			ccrc_q    <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			esc_q   <= (act == ACT_ESC);
			case (act)
				ACT_OPEN, ACT_VERDICT: begin
					count_q   <= '0;
					crc_cnt_q <= '0;
					rcrc_q    <= '0;
					ccrc_q    <= '0;
				end
				ACT_TO_CRC: begin
					crc_cnt_q <= '0;
					rcrc_q    <= '0;
				end
				ACT_PAYLOAD: begin
					count_q <= count_q + 16'd1;
					ccrc_q  <= crc_fold(ccrc_q, dbyte);
				end
				ACT_CRC_BYTE: begin
					crc_cnt_q <= crc_cnt_q + 2'd1;
					if (crc_cnt_q == 2'd0) begin
						rcrc_q[7:0] <= dbyte;
					end else begin
						rcrc_q[15:8] <= dbyte;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

// ===== sv/escaped_frame_crc_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Escaped frame CRC decoder
// Decodes byte-stuffed frames (begin, payload, CRC marker, two CRC bytes low
// first, end) with a CRC-16 check, one received byte per transaction.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while the token queue is not full
// and gives at most one result per byte. The front end classifies each byte
// combinationally into a token queue; the back end retires one token per cycle
// while the result queue has room, folding the CRC-16 a whole byte at a time,
// into a result queue. A byte waits in the token queue and its result in the
// result queue before the ports show it; both queues let either side stall.
// Configuration is written through cfg_we, cfg_index and cfg_data while no
// transaction is in flight.
module escaped_frame_crc_decoder_top import efcd_pkg::*; #(
	parameter int unsigned TOKEN_DEPTH  = 2,
	parameter int unsigned RESULT_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   push,
	output logic                   full,
	input  logic [7:0]             rx_byte,
	output logic                   empty,
	input  logic                   pop,
	output logic [2:0]             kind,
	output logic [7:0]             data_byte,
	output logic [15:0]            frame_length,
	output logic [15:0]            received_crc,
	output logic [15:0]            computed_crc
);

	cfg_t    cfg_q;
	token_t  tok_in;
	token_t  tok_out;
	logic    tok_empty;
	logic    tok_pop;
	logic    res_full;
	logic    res_push;
	result_t res_in;
	result_t res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload   <= RST_MAX_PAYLOAD;
			cfg_q.begin_code    <= RST_BEGIN_CODE;
			cfg_q.end_code      <= RST_END_CODE;
			cfg_q.crc_code      <= RST_CRC_CODE;
			cfg_q.fill_code     <= RST_FILL_CODE;
			cfg_q.escape_code   <= RST_ESCAPE_CODE;
			cfg_q.escaped_codes <= RST_ESCAPED_CODES;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_PAYLOAD:   cfg_q.max_payload   <= cfg_data[15:0];
				REG_BEGIN_CODE:    cfg_q.begin_code    <= cfg_data[7:0];
				REG_END_CODE:      cfg_q.end_code      <= cfg_data[7:0];
				REG_CRC_CODE:      cfg_q.crc_code      <= cfg_data[7:0];
				REG_FILL_CODE:     cfg_q.fill_code     <= cfg_data[7:0];
				REG_ESCAPE_CODE:   cfg_q.escape_code   <= cfg_data[7:0];
				REG_ESCAPED_CODES: cfg_q.escaped_codes <= cfg_data;
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	efcd_front u_front (
		.cfg     (cfg_q),
		.rx_byte (rx_byte),
		.tok     (tok_in)
	);

	efcd_fifo #(
		.WIDTH (TOKEN_W),
		.DEPTH (TOKEN_DEPTH)
	) u_tok_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (tok_in),
		.full   (full),
		.pop    (tok_pop),
		.rdata  (tok_out),
		.empty  (tok_empty)
	);

	efcd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_payload (cfg_q.max_payload),
		.tok_valid   (!tok_empty),
		.tok         (tok_out),
		.tok_pop     (tok_pop),
		.res_full    (res_full),
		.res_push    (res_push),
		.res         (res_in)
	);

	efcd_fifo #(
		.WIDTH (RESULT_W),
		.DEPTH (RESULT_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign kind         = res_out.kind;
	assign data_byte    = res_out.data_byte;
	assign frame_length = res_out.frame_length;
	assign received_crc = res_out.received_crc;
	assign computed_crc = res_out.computed_crc;

endmodule

// ===== bench/tb_escaped_frame_crc_decoder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Escaped frame CRC decoder testbench
// Drives byte streams of directed and randomly built frames through the push
// side under several marker settings and checks every popped result against
// a cycle-free decoder model kept in a scoreboard, with random bursts, gaps
// and receiver stalls.
// ----------------------------------------------------------------------------
module tb_escaped_frame_crc_decoder_top;
	import efcd_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned PHASE_BYTES   = 315;
	localparam int unsigned PHASE_COUNT   = 6;
	localparam int unsigned SETTLE_CYCLES = 8;

	class frame_decode_board;
		cfg_t        cfg;
		phase_t      ph;
		bit          esc_pend;
		logic [15:0] pay_cnt;
		logic [1:0]  crc_cnt;
		logic [15:0] rx_crc;
		logic [15:0] run_crc;
		result_t     decoded_q[$];
		int unsigned failures;

		function new();
			cfg.max_payload   = RST_MAX_PAYLOAD;
			cfg.begin_code    = RST_BEGIN_CODE;
			cfg.end_code      = RST_END_CODE;
			cfg.crc_code      = RST_CRC_CODE;
			cfg.fill_code     = RST_FILL_CODE;
			cfg.escape_code   = RST_ESCAPE_CODE;
			cfg.escaped_codes = RST_ESCAPED_CODES;
			failures = 0;
			restart();
		endfunction

		static function logic [15:0] fold_crc(logic [15:0] c, logic [7:0] b);
			logic [15:0] x;
			x = c ^ {b, 8'h00};
			for (int i = 0; i < 8; i++)
				x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
			return x;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_MAX_PAYLOAD:   cfg.max_payload   = v[15:0];
				REG_BEGIN_CODE:    cfg.begin_code    = v[7:0];
				REG_END_CODE:      cfg.end_code      = v[7:0];
				REG_CRC_CODE:      cfg.crc_code      = v[7:0];
				REG_FILL_CODE:     cfg.fill_code     = v[7:0];
				REG_ESCAPE_CODE:   cfg.escape_code   = v[7:0];
				REG_ESCAPED_CODES: cfg.escaped_codes = v[39:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] unescape(logic [7:0] b);
			logic [7:0] targets[5];
			targets[0] = cfg.begin_code;
			targets[1] = cfg.end_code;
			targets[2] = cfg.crc_code;
			targets[3] = cfg.fill_code;
			targets[4] = cfg.escape_code;
			for (int k = 0; k < 5; k++)
				if (cfg.escaped_codes[8*k +: 8] == b)
					return targets[k];
			return 8'h00;
		endfunction

		function void restart();
			ph       = PH_HUNT;
			esc_pend = 1'b0;
			pay_cnt  = '0;
			crc_cnt  = '0;
			rx_crc   = '0;
			run_crc  = '0;
		endfunction

		function void post(kind_t k, logic [7:0] d, bit with_frame);
			result_t r;
			r.kind         = k;
			r.data_byte    = d;
			r.frame_length = with_frame ? pay_cnt : 16'h0;
			r.received_crc = with_frame ? rx_crc : 16'h0;
			r.computed_crc = with_frame ? run_crc : 16'h0;
			decoded_q.push_back(r);
		endfunction

		function void close_frame(kind_t k, bit with_frame);
			post(k, 8'h00, with_frame);
			restart();
		endfunction

		function void take_data(logic [7:0] b);
			if (ph == PH_PAYLOAD) begin
				if (pay_cnt >= cfg.max_payload) begin
					close_frame(KIND_OVERFLOW, 1'b1);
				end else begin
					run_crc = fold_crc(run_crc, b);
					pay_cnt = pay_cnt + 16'd1;
					post(KIND_PAYLOAD, b, 1'b0);
				end
			end else if (crc_cnt >= 2'd2) begin
				close_frame(KIND_OVERFLOW, 1'b1);
			end else begin
				rx_crc  = rx_crc | (16'(b) << (8 * crc_cnt));
				crc_cnt = crc_cnt + 2'd1;
			end
		endfunction

		function void note_byte(logic [7:0] b);
			bit in_frame;
			in_frame = (ph != PH_HUNT);
			if (esc_pend && in_frame) begin
				esc_pend = 1'b0;
				take_data(unescape(b));
				return;
			end
			esc_pend = 1'b0;
			if (b == cfg.begin_code) begin
				if (!in_frame) begin
					restart();
					ph = PH_PAYLOAD;
				end else begin
					close_frame(KIND_MARKER, 1'b1);
				end
			end else if (b == cfg.fill_code) begin
			end else if (b == cfg.end_code) begin
				if (ph == PH_CRC)
					close_frame((rx_crc == run_crc) ? KIND_GOOD : KIND_BADCRC, 1'b1);
				else
					close_frame(KIND_MARKER, in_frame);
			end else if (b == cfg.crc_code) begin
				if (ph == PH_PAYLOAD) begin
					ph      = PH_CRC;
					crc_cnt = '0;
					rx_crc  = '0;
				end else begin
					close_frame(KIND_MARKER, in_frame);
				end
			end else if (in_frame) begin
				if (b == cfg.escape_code)
					esc_pend = 1'b1;
				else
					take_data(b);
			end
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (decoded_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: kind=%0d data=%02h len=%0d rcrc=%04h ccrc=%04h",
						got.kind, got.data_byte, got.frame_length, got.received_crc,
						got.computed_crc);
				return;
			end
			exp = decoded_q.pop_front();
			if (got.kind !== exp.kind || got.data_byte !== exp.data_byte ||
					got.frame_length !== exp.frame_length ||
					got.received_crc !== exp.received_crc ||
					got.computed_crc !== exp.computed_crc) begin
				failures++;
				if (failures <= 10) begin
					$display("mismatch at %0t: exp kind=%0d data=%02h len=%0d rcrc=%04h ccrc=%04h",
						$realtime, exp.kind, exp.data_byte, exp.frame_length,
						exp.received_crc, exp.computed_crc);
					$display("                  got kind=%0d data=%02h len=%0d rcrc=%04h ccrc=%04h",
						got.kind, got.data_byte, got.frame_length, got.received_crc,
						got.computed_crc);
				end
			end
		endfunction

		function int pending();
			return decoded_q.size();
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   push      = 1'b0;
	logic [7:0]             rx_byte   = 8'h00;
	logic                   pop       = 1'b0;
	logic                   full;
	logic                   empty;
	logic [2:0]             kind;
	logic [7:0]             data_byte;
	logic [15:0]            frame_length;
	logic [15:0]            received_crc;
	logic [15:0]            computed_crc;

	frame_decode_board sb = new();

	logic [7:0]  frame_bytes[$];
	int unsigned burst_left   = 0;
	bit          steady       = 1'b0;
	int unsigned phase_sent   = 0;
	int unsigned cycles       = 0;
	int unsigned results_seen = 0;
	int unsigned rx_mode      = 0;
	int unsigned mode_left    = 0;
	int unsigned hold_left    = 0;
	bit          held_long    = 1'b0;

	localparam logic [7:0] DIRECTED [31] = '{
		8'h55, RST_ESCAPE_CODE, RST_END_CODE, RST_CRC_CODE,
		RST_BEGIN_CODE, 8'h00, 8'hFF, RST_FILL_CODE, RST_ESCAPE_CODE, 8'h83,
		RST_BEGIN_CODE,
		RST_BEGIN_CODE, RST_ESCAPE_CODE, 8'h77, RST_END_CODE,
		RST_BEGIN_CODE, 8'h11, 8'h22, 8'h33, 8'h44,
		RST_BEGIN_CODE, RST_CRC_CODE, RST_CRC_CODE,
		RST_BEGIN_CODE, RST_CRC_CODE, RST_END_CODE,
		RST_BEGIN_CODE, RST_CRC_CODE, 8'h10, 8'h20, 8'h30
	};

	escaped_frame_crc_decoder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.kind         (kind),
		.data_byte    (data_byte),
		.frame_length (frame_length),
		.received_crc (received_crc),
		.computed_crc (computed_crc)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: check popped transaction, then pick the next pop on its own pattern
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				sb.check_result({kind, data_byte, frame_length, received_crc, computed_crc});
				results_seen++;
			end
			if (mode_left == 0) begin
				rx_mode   = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			if (!held_long && results_seen >= 200) begin
				held_long = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (rx_mode)
					0: pop <= 1'b1;
					1: pop <= ($urandom_range(0, 1) == 0);
					2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= (cycles[2:0] != 3'd0);
				endcase
			end
		end
	end

	task automatic offer(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0 || steady) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		push    <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_byte(b);
		burst_left--;
		phase_sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_t c);
		cfg_reg_t        r;
		logic [CFG_DATA_W-1:0] v;
		r = r.first();
		repeat (r.num()) begin
			case (r)
				REG_MAX_PAYLOAD:   v = CFG_DATA_W'(c.max_payload);
				REG_BEGIN_CODE:    v = CFG_DATA_W'(c.begin_code);
				REG_END_CODE:      v = CFG_DATA_W'(c.end_code);
				REG_CRC_CODE:      v = CFG_DATA_W'(c.crc_code);
				REG_FILL_CODE:     v = CFG_DATA_W'(c.fill_code);
				REG_ESCAPE_CODE:   v = CFG_DATA_W'(c.escape_code);
				default:           v = c.escaped_codes;
			endcase
			cfg_we    <= 1'b1;
			cfg_index <= r;
			cfg_data  <= v;
			@(posedge clk);
			sb.set_reg(r, v);
			r = r.next();
		end
		cfg_we <= 1'b0;
	endtask

	function automatic bit is_marker(logic [7:0] b);
		return b == sb.cfg.begin_code || b == sb.cfg.end_code || b == sb.cfg.crc_code ||
			b == sb.cfg.fill_code || b == sb.cfg.escape_code;
	endfunction

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 4) != 0)
			return 8'($urandom);
		case ($urandom_range(0, 4))
			0: return sb.cfg.begin_code;
			1: return sb.cfg.end_code;
			2: return sb.cfg.crc_code;
			3: return sb.cfg.fill_code;
			default: return sb.cfg.escape_code;
		endcase
	endfunction

	// stuff a data byte: escape marker values when the table has a follower, sometimes add a fill
	function automatic void put_data(logic [7:0] b);
		int f;
		f = -1;
		if (is_marker(b))
			for (int i = 0; i < 256; i++)
				if (f < 0 && sb.unescape(8'(i)) == b)
					f = i;
		if (f >= 0) begin
			frame_bytes.push_back(sb.cfg.escape_code);
			frame_bytes.push_back(8'(f));
		end else begin
			frame_bytes.push_back(b);
		end
		if ($urandom_range(0, 11) == 0)
			frame_bytes.push_back(sb.cfg.fill_code);
	endfunction

	task automatic send_frame();
		int unsigned len;
		int unsigned lim;
		int unsigned flaw;
		logic [15:0] crc;
		logic [7:0]  b;
		frame_bytes.delete();
		crc  = 16'h0;
		flaw = $urandom_range(0, 9);
		lim  = (sb.cfg.max_payload > 10) ? 10 : sb.cfg.max_payload;
		if (sb.cfg.max_payload <= 16 && $urandom_range(0, 3) == 0)
			len = sb.cfg.max_payload + $urandom_range(0, 1);
		else
			len = $urandom_range(0, lim);
		frame_bytes.push_back(sb.cfg.begin_code);
		for (int i = 0; i < len; i++) begin
			b   = pick_byte();
			crc = frame_decode_board::fold_crc(crc, b);
			put_data(b);
			if (flaw == 4 && i == 0)
				frame_bytes.push_back(sb.cfg.begin_code);
		end
		if (flaw == 0)
			crc = crc ^ 16'($urandom_range(1, 65535));
		if (flaw != 3) begin
			frame_bytes.push_back(sb.cfg.crc_code);
			if (flaw != 1) begin
				put_data(crc[7:0]);
				put_data(crc[15:8]);
			end else if ($urandom_range(0, 1) == 1) begin
				put_data(crc[7:0]);
			end
			if (flaw == 2)
				put_data(pick_byte());
		end
		frame_bytes.push_back(sb.cfg.end_code);
		foreach (frame_bytes[i])
			offer(frame_bytes[i]);
	endtask

	function automatic cfg_t random_cfg(bit distinct, int unsigned max_hi);
		cfg_t        c;
		bit          used[256];
		logic [7:0]  v[10];
		for (int i = 0; i < 10; i++) begin
			v[i] = 8'($urandom);
			while (distinct && used[v[i]])
				v[i] = 8'($urandom);
			used[v[i]] = 1'b1;
		end
		c.max_payload   = 16'($urandom_range(1, max_hi));
		c.begin_code    = v[0];
		c.end_code      = v[1];
		c.crc_code      = v[2];
		c.fill_code     = v[3];
		c.escape_code   = v[4];
		c.escaped_codes = {v[9], v[8], v[7], v[6], v[5]};
		return c;
	endfunction

	function automatic cfg_t phase_cfg(int unsigned p);
		cfg_t c;
		case (p)
			1: c = '{RST_MAX_PAYLOAD, RST_BEGIN_CODE, RST_END_CODE, RST_CRC_CODE,
				RST_FILL_CODE, RST_ESCAPE_CODE, 40'h64_5E_44_43_42};
			2: c = '{16'd1, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 40'hFF_FF_FF_FF_FF};
			3: begin
				c = random_cfg(1'b1, 1);
				c.max_payload = 16'hFFFF;
			end
			4: c = random_cfg(1'b0, 20);
			5: c = random_cfg(1'b1, 8);
			default: c = '{16'd2, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'hFE, 40'h0};
		endcase
		return c;
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_cfg('{16'd3, RST_BEGIN_CODE, RST_END_CODE, RST_CRC_CODE, RST_FILL_CODE,
			RST_ESCAPE_CODE, 40'hA4_83_84_83_82});
		foreach (DIRECTED[i])
			offer(DIRECTED[i]);
		drain();

		for (int unsigned p = 1; p <= PHASE_COUNT; p++) begin
			write_cfg(phase_cfg(p));
			steady     = (p == 3);
			phase_sent = 0;
			while (phase_sent < PHASE_BYTES) begin
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 4)) offer(pick_byte());
				send_frame();
			end
			drain();
		end

		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== escaped_frame_crc_decoder_top.f =====
sv/efcd_pkg.sv
sv/efcd_fifo.sv
sv/efcd_front.sv
sv/efcd_back.sv
sv/escaped_frame_crc_decoder_top.sv
bench/tb_escaped_frame_crc_decoder_top.sv
